FILE: hdl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every rising clock edge outside reset.
`define SBA_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define SBA_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/sba_pkg.sv
// Types, codes and sizes of the subpool buffer allocator.
// Used by the interfaces, the link memory and the top level.
package sba_pkg;

   localparam int unsigned MAX_SUBPOOLS     = 8;
   localparam int unsigned MAX_BUFFERS      = 256;
   localparam int unsigned MAX_BUFFER_BYTES = 65536;

   localparam int unsigned SP_W    = 3;
   localparam int unsigned SPC_W   = 4;
   localparam int unsigned BUF_W   = 8;
   localparam int unsigned CNT_W   = 9;
   localparam int unsigned BYTES_W = 17;
   localparam int unsigned ADDR_W  = 24;
   localparam int unsigned IDX_W   = 2;

   localparam logic [CNT_W-1:0]   INIT_BUFS_RESET = CNT_W'(16);
   localparam logic [BYTES_W-1:0] BUF_BYTES_RESET = BYTES_W'(1024);

   localparam logic [IDX_W-1:0] CSR_INITIAL_BUFS = IDX_W'(0);
   localparam logic [IDX_W-1:0] CSR_BUFFER_BYTES = IDX_W'(1);

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_EMPTY        = 3'd1,
      ST_DELETED      = 3'd2,
      ST_INVALID      = 3'd3,
      ST_FULL         = 3'd4,
      ST_INCONSISTENT = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_EXPAND  = 2'd2,
      REQ_DELETE  = 2'd3
   } req_kind_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_FILL   = 6'b000010,
      S_SEARCH = 6'b000100,
      S_LINK   = 6'b001000,
      S_REL    = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   typedef struct packed {
      logic             en;
      logic [BUF_W-1:0] addr;
      logic [BUF_W-1:0] data;
   } link_wr_type;

endpackage

FILE: hdl/sba_if.sv
// Channel interfaces of the allocator: request, response and register write.
// Depends on sba_pkg for field widths.
interface sba_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 req_type;
   logic [sba_pkg::BUF_W-1:0]  buf_number;
   logic [sba_pkg::CNT_W-1:0]  add_count;
   modport source (output valid, req_type, buf_number, add_count, input ready);
   modport sink (input valid, req_type, buf_number, add_count, output ready);
endinterface

interface sba_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  status;
   logic [sba_pkg::BUF_W-1:0]   granted_buf;
   logic [sba_pkg::ADDR_W-1:0]  byte_address;
   logic [sba_pkg::SP_W-1:0]    owner_subpool;
   logic [sba_pkg::CNT_W-1:0]   free_total;
   modport source (output valid, status, granted_buf, byte_address, owner_subpool,
                   free_total, input ready);
   modport sink (input valid, status, granted_buf, byte_address, owner_subpool,
                 free_total, output ready);
endinterface

interface sba_csr_if;
   logic                         valid;
   logic                         ready;
   logic [sba_pkg::IDX_W-1:0]    index;
   logic [sba_pkg::BYTES_W-1:0]  wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

FILE: hdl/sba_link_ram.sv
// Free-list link memory: one write port, one read port, registered read data.
// Depends on sba_pkg for sizes and the write struct.
module sba_link_ram (
   input  logic                        clock,
   input  sba_pkg::link_wr_type        wr,
   input  logic [sba_pkg::BUF_W-1:0]   rd_addr,
   output logic [sba_pkg::BUF_W-1:0]   rd_data
);

   logic [sba_pkg::BUF_W-1:0] mem [sba_pkg::MAX_BUFFERS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/subpool_buffer_allocator.sv
// Top level of the subpool buffer allocator: control sequencer and subpool table.
// Depends on sba_pkg, the channel interfaces, sba_link_ram and assert_macros.svh.
//
// The pool holds up to 256 buffers in up to 8 contiguous subpools, each with
// a LIFO free list kept in a link memory. A request transaction on req_chan
// asks to allocate, release, expand or delete; each produces exactly one
// response transaction on rsp_chan. Register writes arrive on csr_chan:
// index 0 sets the first subpool size and reinitializes the pool, index 1
// sets the bytes per buffer.
// Allocate passes through the search, link and response states; the search
// visits one subpool a cycle, and the link state grants the head buffer and
// takes the next head from the registered link memory read. An allocate refused
// on a deleted or empty pool, a delete and a refused expand go straight to the
// response state. Release passes through the release state; expand writes the
// new links in the fill state, one entry a cycle, before the response state.
// After reset and after a write to register 0, the first subpool's links are
// written one per cycle; req_chan.ready stays low.
// One request is in work at a time. A finished response waits in an output
// register while the next request is accepted and processed; the block only
// stalls when a new response is ready and the old one has not been taken.
`include "assert_macros.svh"

module subpool_buffer_allocator (
   input logic      clock,
   input logic      reset,
   sba_req_if.sink  req_chan,
   sba_rsp_if.source rsp_chan,
   sba_csr_if.sink  csr_chan
);

   localparam int unsigned NSP = sba_pkg::MAX_SUBPOOLS;

   sba_pkg::state_type                state_ff, state_in;
   logic [sba_pkg::BYTES_W-1:0]       bytes_ff, bytes_in;
   logic [sba_pkg::BUF_W-1:0]         sub_start_ff [NSP];
   logic [sba_pkg::BUF_W-1:0]         sub_start_in [NSP];
   logic [sba_pkg::CNT_W-1:0]         sub_size_ff [NSP];
   logic [sba_pkg::CNT_W-1:0]         sub_size_in [NSP];
   logic [sba_pkg::CNT_W-1:0]         sub_free_ff [NSP];
   logic [sba_pkg::CNT_W-1:0]         sub_free_in [NSP];
   logic [sba_pkg::BUF_W-1:0]         sub_head_ff [NSP];
   logic [sba_pkg::BUF_W-1:0]         sub_head_in [NSP];
   logic [sba_pkg::SPC_W-1:0]         count_ff, count_in;
   logic [sba_pkg::SP_W-1:0]          hint_ff, hint_in;
   logic [sba_pkg::CNT_W-1:0]         pool_free_ff, pool_free_in;
   logic [sba_pkg::CNT_W-1:0]         pool_size_ff, pool_size_in;
   logic                              deleted_ff, deleted_in;
   logic [sba_pkg::SP_W-1:0]          sel_ff, sel_in;
   logic [sba_pkg::SP_W-1:0]          step_ff, step_in;
   logic [sba_pkg::BUF_W-1:0]         bnum_ff, bnum_in;
   logic [sba_pkg::BUF_W-1:0]         fill_base_ff, fill_base_in;
   logic [sba_pkg::CNT_W-1:0]         fill_idx_ff, fill_idx_in;
   logic [sba_pkg::CNT_W-1:0]         fill_n_ff, fill_n_in;
   logic                              fill_cfg_ff, fill_cfg_in;
   sba_pkg::status_type               res_status_ff, res_status_in;
   logic [sba_pkg::BUF_W-1:0]         res_granted_ff, res_granted_in;
   logic [sba_pkg::ADDR_W-1:0]        res_addr_ff, res_addr_in;
   logic [sba_pkg::SP_W-1:0]          res_owner_ff, res_owner_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   sba_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [sba_pkg::BUF_W-1:0]         rsp_granted_ff, rsp_granted_in;
   logic [sba_pkg::ADDR_W-1:0]        rsp_addr_ff, rsp_addr_in;
   logic [sba_pkg::SP_W-1:0]          rsp_owner_ff, rsp_owner_in;
   logic [sba_pkg::CNT_W-1:0]         rsp_free_ff, rsp_free_in;

   sba_pkg::link_wr_type              link_wr;
   logic [sba_pkg::BUF_W-1:0]         link_rd_data;
   logic [sba_pkg::BUF_W-1:0]         alloc_buf;
   logic [sba_pkg::BUF_W+sba_pkg::BYTES_W-1:0] alloc_prod;
   logic [sba_pkg::SP_W-1:0]          rel_sel;
   logic                              rel_found;
   logic [sba_pkg::CNT_W-1:0]         add_n;
   logic [sba_pkg::CNT_W:0]           grow_sum;
   logic [sba_pkg::BUF_W-1:0]         fill_addr;
   logic                              fill_last;
   logic [sba_pkg::CNT_W-1:0]         init_n;
   logic [sba_pkg::CNT_W-1:0]         rel_free_new;
   logic [sba_pkg::CNT_W-1:0]         rel_hint_free;
   logic                              req_fire;
   logic                              csr_fire;

   sba_link_ram u_link_ram (
      .clock   (clock),
      .wr      (link_wr),
      .rd_addr (sub_head_ff[sel_ff]),
      .rd_data (link_rd_data)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;

   assign req_chan.ready = (state_ff == sba_pkg::S_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.granted_buf   = rsp_granted_ff;
   assign rsp_chan.byte_address  = rsp_addr_ff;
   assign rsp_chan.owner_subpool = rsp_owner_ff;
   assign rsp_chan.free_total    = rsp_free_ff;

   assign alloc_buf  = sub_head_ff[sel_ff];
   assign alloc_prod = {{sba_pkg::BYTES_W{1'b0}}, alloc_buf}
                     * {{sba_pkg::BUF_W{1'b0}}, bytes_ff};

   assign add_n    = (req_chan.add_count == '0) ? sba_pkg::CNT_W'(1) : req_chan.add_count;
   assign grow_sum = {1'b0, pool_size_ff} + {1'b0, add_n};

   assign fill_addr = fill_base_ff + fill_idx_ff[sba_pkg::BUF_W-1:0];
   assign fill_last = (({1'b0, fill_idx_ff} + (sba_pkg::CNT_W+1)'(1)) == {1'b0, fill_n_ff});

   // The first subpool whose number range holds the released buffer.
   always_comb begin
      rel_sel   = '0;
      rel_found = 1'b0;
      for (int k = NSP - 1; k >= 0; k--) begin
         if ((sba_pkg::SPC_W'(k) < count_ff)
             && (bnum_ff >= sub_start_ff[k])
             && ({2'b00, bnum_ff} < ({2'b00, sub_start_ff[k]} + {1'b0, sub_size_ff[k]}))) begin
            rel_sel   = sba_pkg::SP_W'(k);
            rel_found = 1'b1;
         end
      end
   end

   assign rel_free_new  = sub_free_ff[rel_sel] + sba_pkg::CNT_W'(1);
   assign rel_hint_free = (hint_ff == rel_sel) ? rel_free_new : sub_free_ff[hint_ff];

   always_comb begin
      if (csr_chan.wdata[sba_pkg::CNT_W-1:0] == '0) begin
         init_n = sba_pkg::CNT_W'(1);
      end else if (csr_chan.wdata[sba_pkg::CNT_W-1:0] > sba_pkg::CNT_W'(sba_pkg::MAX_BUFFERS)) begin
         init_n = sba_pkg::CNT_W'(sba_pkg::MAX_BUFFERS);
      end else begin
         init_n = csr_chan.wdata[sba_pkg::CNT_W-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      bytes_in       = bytes_ff;
      sub_start_in   = sub_start_ff;
      sub_size_in    = sub_size_ff;
      sub_free_in    = sub_free_ff;
      sub_head_in    = sub_head_ff;
      count_in       = count_ff;
      hint_in        = hint_ff;
      pool_free_in   = pool_free_ff;
      pool_size_in   = pool_size_ff;
      deleted_in     = deleted_ff;
      sel_in         = sel_ff;
      step_in        = step_ff;
      bnum_in        = bnum_ff;
      fill_base_in   = fill_base_ff;
      fill_idx_in    = fill_idx_ff;
      fill_n_in      = fill_n_ff;
      fill_cfg_in    = fill_cfg_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      res_addr_in    = res_addr_ff;
      res_owner_in   = res_owner_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_owner_in   = rsp_owner_ff;
      rsp_free_in    = rsp_free_ff;
      link_wr        = '0;

      case (state_ff)
         sba_pkg::S_IDLE: begin
            if (req_fire) begin
               res_status_in  = sba_pkg::ST_OK;
               res_granted_in = '0;
               res_addr_in    = '0;
               res_owner_in   = '0;
               bnum_in        = req_chan.buf_number;
               state_in       = sba_pkg::S_RESP;
               case (req_chan.req_type)
                  sba_pkg::REQ_ALLOC: begin
                     if (deleted_ff) begin
                        res_status_in = sba_pkg::ST_DELETED;
                     end else if (pool_free_ff == '0) begin
                        res_status_in = sba_pkg::ST_EMPTY;
                     end else begin
                        sel_in   = hint_ff;
                        step_in  = '0;
                        state_in = sba_pkg::S_SEARCH;
                     end
                  end
                  sba_pkg::REQ_RELEASE: begin
                     state_in = sba_pkg::S_REL;
                  end
                  sba_pkg::REQ_EXPAND: begin
                     if ((count_ff >= sba_pkg::SPC_W'(NSP))
                         || (grow_sum > (sba_pkg::CNT_W+1)'(sba_pkg::MAX_BUFFERS))) begin
                        res_status_in = sba_pkg::ST_FULL;
                     end else begin
                        sub_start_in[count_ff[sba_pkg::SP_W-1:0]] = pool_size_ff[sba_pkg::BUF_W-1:0];
                        sub_size_in[count_ff[sba_pkg::SP_W-1:0]]  = add_n;
                        sub_free_in[count_ff[sba_pkg::SP_W-1:0]]  = add_n;
                        sub_head_in[count_ff[sba_pkg::SP_W-1:0]]  = pool_size_ff[sba_pkg::BUF_W-1:0];
                        count_in     = count_ff + sba_pkg::SPC_W'(1);
                        pool_size_in = grow_sum[sba_pkg::CNT_W-1:0];
                        pool_free_in = pool_free_ff + add_n;
                        if (add_n > sub_free_ff[hint_ff]) begin
                           hint_in = count_ff[sba_pkg::SP_W-1:0];
                        end
                        res_owner_in = count_ff[sba_pkg::SP_W-1:0];
                        fill_base_in = pool_size_ff[sba_pkg::BUF_W-1:0];
                        fill_idx_in  = '0;
                        fill_n_in    = add_n;
                        fill_cfg_in  = 1'b0;
                        state_in     = sba_pkg::S_FILL;
                     end
                  end
                  sba_pkg::REQ_DELETE: begin
                     deleted_in = 1'b1;
                  end
                  default: begin
                     deleted_in = deleted_ff;
                  end
               endcase
            end
         end
         sba_pkg::S_FILL: begin
            link_wr.en   = 1'b1;
            link_wr.addr = fill_addr;
            link_wr.data = fill_last ? '0 : fill_addr + sba_pkg::BUF_W'(1);
            fill_idx_in  = fill_idx_ff + sba_pkg::CNT_W'(1);
            if (fill_last) begin
               state_in = fill_cfg_ff ? sba_pkg::S_IDLE : sba_pkg::S_RESP;
            end
         end
         sba_pkg::S_SEARCH: begin
            if (sub_free_ff[sel_ff] != '0) begin
               state_in = sba_pkg::S_LINK;
            end else if (({1'b0, step_ff} + sba_pkg::SPC_W'(1)) >= count_ff) begin
               res_status_in = sba_pkg::ST_INCONSISTENT;
               state_in      = sba_pkg::S_RESP;
            end else begin
               step_in = step_ff + sba_pkg::SP_W'(1);
               sel_in  = (sel_ff == '0) ? sba_pkg::SP_W'(count_ff - sba_pkg::SPC_W'(1))
                                        : sel_ff - sba_pkg::SP_W'(1);
            end
         end
         sba_pkg::S_LINK: begin
            sub_head_in[sel_ff] = link_rd_data;
            sub_free_in[sel_ff] = sub_free_ff[sel_ff] - sba_pkg::CNT_W'(1);
            pool_free_in        = pool_free_ff - sba_pkg::CNT_W'(1);
            hint_in             = sel_ff;
            res_granted_in      = alloc_buf;
            res_addr_in         = alloc_prod[sba_pkg::ADDR_W-1:0];
            res_owner_in        = sel_ff;
            state_in            = sba_pkg::S_RESP;
         end
         sba_pkg::S_REL: begin
            state_in = sba_pkg::S_RESP;
            if (!rel_found || ({1'b0, bnum_ff} >= pool_size_ff)) begin
               res_status_in = sba_pkg::ST_INVALID;
            end else if (sub_free_ff[rel_sel] >= sub_size_ff[rel_sel]) begin
               res_status_in = sba_pkg::ST_INCONSISTENT;
            end else begin
               link_wr.en           = 1'b1;
               link_wr.addr         = bnum_ff;
               link_wr.data         = sub_head_ff[rel_sel];
               sub_head_in[rel_sel] = bnum_ff;
               sub_free_in[rel_sel] = rel_free_new;
               pool_free_in         = pool_free_ff + sba_pkg::CNT_W'(1);
               if (rel_free_new > rel_hint_free) begin
                  hint_in = rel_sel;
               end
               res_owner_in = rel_sel;
            end
         end
         sba_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_granted_in = res_granted_ff;
               rsp_addr_in    = res_addr_ff;
               rsp_owner_in   = res_owner_ff;
               rsp_free_in    = pool_free_ff;
               state_in       = sba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sba_pkg::S_IDLE;
         end
      endcase

      if (csr_fire && (csr_chan.index == sba_pkg::CSR_BUFFER_BYTES)) begin
         if (csr_chan.wdata == '0) begin
            bytes_in = sba_pkg::BYTES_W'(1);
         end else if (csr_chan.wdata > sba_pkg::BYTES_W'(sba_pkg::MAX_BUFFER_BYTES)) begin
            bytes_in = sba_pkg::BYTES_W'(sba_pkg::MAX_BUFFER_BYTES);
         end else begin
            bytes_in = csr_chan.wdata;
         end
      end

      if (csr_fire && (csr_chan.index == sba_pkg::CSR_INITIAL_BUFS)) begin
         for (int k = 0; k < NSP; k++) begin
            sub_start_in[k] = '0;
            sub_size_in[k]  = '0;
            sub_free_in[k]  = '0;
            sub_head_in[k]  = '0;
         end
         sub_size_in[0] = init_n;
         sub_free_in[0] = init_n;
         count_in       = sba_pkg::SPC_W'(1);
         hint_in        = '0;
         pool_free_in   = init_n;
         pool_size_in   = init_n;
         deleted_in     = 1'b0;
         fill_base_in   = '0;
         fill_idx_in    = '0;
         fill_n_in      = init_n;
         fill_cfg_in    = 1'b1;
         state_in       = sba_pkg::S_FILL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sba_pkg::S_FILL;
         bytes_ff     <= sba_pkg::BUF_BYTES_RESET;
         for (int k = 0; k < NSP; k++) begin
            sub_start_ff[k] <= '0;
            sub_size_ff[k]  <= '0;
            sub_free_ff[k]  <= '0;
            sub_head_ff[k]  <= '0;
         end
         sub_size_ff[0] <= sba_pkg::INIT_BUFS_RESET;
         sub_free_ff[0] <= sba_pkg::INIT_BUFS_RESET;
         count_ff       <= sba_pkg::SPC_W'(1);
         hint_ff        <= '0;
         pool_free_ff   <= sba_pkg::INIT_BUFS_RESET;
         pool_size_ff   <= sba_pkg::INIT_BUFS_RESET;
         deleted_ff     <= 1'b0;
         fill_base_ff   <= '0;
         fill_idx_ff    <= '0;
         fill_n_ff      <= sba_pkg::INIT_BUFS_RESET;
         fill_cfg_ff    <= 1'b1;
         sel_ff         <= '0;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bytes_ff     <= bytes_in;
         sub_start_ff <= sub_start_in;
         sub_size_ff  <= sub_size_in;
         sub_free_ff  <= sub_free_in;
         sub_head_ff  <= sub_head_in;
         count_ff     <= count_in;
         hint_ff      <= hint_in;
         pool_free_ff <= pool_free_in;
         pool_size_ff <= pool_size_in;
         deleted_ff   <= deleted_in;
         fill_base_ff <= fill_base_in;
         fill_idx_ff  <= fill_idx_in;
         fill_n_ff    <= fill_n_in;
         fill_cfg_ff  <= fill_cfg_in;
         sel_ff       <= sel_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bnum_ff        <= bnum_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      res_addr_ff    <= res_addr_in;
      res_owner_ff   <= res_owner_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_owner_ff   <= rsp_owner_in;
      rsp_free_ff    <= rsp_free_in;
   end

   `SBA_ASSERT_ALWAYS(a_hint_in_range, clock, reset, ({1'b0, hint_ff} < count_ff), "hint subpool beyond subpool count")
   `SBA_ASSERT_ALWAYS(a_free_le_size, clock, reset, (pool_free_ff <= pool_size_ff), "free buffers exceed pool size")
   `SBA_ASSERT_ALWAYS(a_count_range, clock, reset, ((count_ff != '0) && (count_ff <= sba_pkg::SPC_W'(NSP))), "subpool count out of range")
   `SBA_ASSERT_IMPLIES(a_fill_bound, clock, reset, (state_ff == sba_pkg::S_FILL), (fill_idx_ff < fill_n_ff), "link fill ran past its run")

endmodule
